/* rtl/per_source_token_bucket_policer_assert.svh */
// assertion macros shared by the policer rtl
`ifndef PER_SOURCE_TOKEN_BUCKET_POLICER_ASSERT_SVH
`define PER_SOURCE_TOKEN_BUCKET_POLICER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PSTB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pstb_pkg.sv */
`default_nettype none
package pstb_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int RATE_W  = 20;
    localparam int TOK_W   = 20;
    localparam int TIME_W  = 64;
    localparam int PROD_W  = TIME_W + RATE_W;
    localparam int CFG_IDX_W = 2;

    // floor(p / 1e9) for p < 2^50 is ((p >> 9) * RECIP) >> 62
    localparam int MPL_W       = 42;
    localparam int RECIP_SHIFT = 62;
    localparam int QUO_W       = 21;
    localparam int SAT_BIT     = 50;
    localparam int DIV_IN_LSB  = 9;
    localparam logic [MPL_W-1:0] RECIP = 42'd2361183241435;

    localparam logic [RATE_W-1:0] DEF_RATE  = 20'd1000;
    localparam logic [TOK_W-1:0]  DEF_BURST = 20'd2000;
    localparam logic [15:0]       MIN_FRAME  = 16'd34;
    localparam logic [15:0]       ETYPE_IPV4 = 16'h0800;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd1;

    localparam logic [1:0] REASON_BYPASS = 2'd0;
    localparam logic [1:0] REASON_FULL   = 2'd1;
    localparam logic [1:0] REASON_SPENT  = 2'd2;
    localparam logic [1:0] REASON_EMPTY  = 2'd3;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] source_addr;
        logic [63:0] arrival_time_ns;
    } t_in;

    typedef struct packed {
        logic       drop;
        logic [1:0] reason;
    } t_out;

    typedef struct packed {
        logic [31:0]       key;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] last_time;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_CMP, ST_MISS, ST_MUL, ST_RECIP, ST_UPD, ST_OUT
    } t_state;

endpackage
`default_nettype wire

/* rtl/pstb_ram.sv */
`default_nettype none
module pstb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/per_source_token_bucket_policer.sv */
`default_nettype none
// Per-source token bucket policer. One header beat in, one verdict beat out.
// Short or non-IPv4 frames go from idle straight to the output state.
// Otherwise the source table (one RAM, entries filled in order, never
// removed) is searched one entry at a time, a read state and then a compare
// state per entry, through its registered read port. On a miss a new source
// is written right after the search with a full bucket less one token for
// this frame; a table-full miss passes untracked. A hit runs elapsed time
// times rate on a shared shift-add unit, then the same unit multiplies by a
// reciprocal of 1e9. The input is stalled while an item is in work; a verdict
// waits in an output register so the next beat can enter, and a stalled
// output holds the next item in the output state until the held verdict is taken.
module per_source_token_bucket_policer #(
    parameter int TABLE_ENTRIES = pstb_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire pstb_pkg::t_in                  i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output pstb_pkg::t_out                      o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [pstb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pstb_pkg::RATE_W-1:0]    i_cfg_wdata
);
    import pstb_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] ENTRIES = CW'(TABLE_ENTRIES);
    localparam logic [6:0] MUL_LAST = 7'(RATE_W - 1);
    localparam logic [6:0] REC_LAST = 7'(MPL_W - 1);

    t_state r_state, n_state;
    logic [RATE_W-1:0] r_rate;
    logic [TOK_W-1:0]  r_burst;
    logic [CW-1:0]     r_used, n_used;
    logic [CW-1:0]     r_idx, n_idx;
    t_in               r_item, n_item;
    logic [TOK_W-1:0]  r_tok, n_tok;
    logic [TIME_W-1:0] r_last, n_last;
    logic [TIME_W-1:0] r_delta, n_delta;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [MPL_W-1:0]  r_mpl, n_mpl;
    logic              r_sat, n_sat;
    logic [6:0]        r_cnt, n_cnt;
    t_out              r_res, n_res;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;

    logic              in_beat;
    logic              bypass;
    logic              key_hit;
    logic              last_probe;
    logic [PROD_W-1:0] mac_next;
    logic [QUO_W-1:0]  refill;
    logic [QUO_W:0]    tok_sum;
    logic [TOK_W-1:0]  tok_new;

    pstb_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // decode helpers
    assign in_beat    = i_in_valid && !o_in_stall;
    assign bypass     = (i_in_data.frame_length < MIN_FRAME)
                     || (i_in_data.ether_type != ETYPE_IPV4);
    assign key_hit    = (ram_rdata.key == r_item.source_addr);
    assign last_probe = ((r_idx + 1'b1) == r_used);

    // shared shift-add step, multiplier msb first
    assign mac_next   = {r_prod[PROD_W-2:0], 1'b0}
                      + (r_mpl[MPL_W-1] ? {{RATE_W{1'b0}}, r_delta} : '0);

    // refill quotient, saturated when the product is past any burst
    assign refill     = r_sat ? '1 : r_prod[RECIP_SHIFT +: QUO_W];
    assign tok_sum    = {1'b0, refill} + {{(QUO_W+1-TOK_W){1'b0}}, r_tok};
    assign tok_new    = (refill == '0) ? r_tok
                      : (tok_sum > {{(QUO_W+1-TOK_W){1'b0}}, r_burst}) ? r_burst
                      : tok_sum[TOK_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if (bypass) begin
                        n_state = ST_OUT;
                    end else if (r_used == '0) begin
                        n_state = ST_MISS;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD:   n_state = ST_CMP;
            ST_CMP: begin
                if (key_hit) begin
                    n_state = ST_MUL;
                end else if (last_probe) begin
                    n_state = ST_MISS;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_MISS:  n_state = ST_OUT;
            ST_MUL:   n_state = (r_cnt == MUL_LAST) ? ST_RECIP : ST_MUL;
            ST_RECIP: n_state = (r_cnt == REC_LAST) ? ST_UPD : ST_RECIP;
            ST_UPD:   n_state = ST_OUT;
            ST_OUT:   n_state = (!r_out_valid || !i_out_stall) ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb begin
        n_used      = r_used;
        n_idx       = r_idx;
        n_item      = r_item;
        n_tok       = r_tok;
        n_last      = r_last;
        n_delta     = r_delta;
        n_prod      = r_prod;
        n_mpl       = r_mpl;
        n_sat       = r_sat;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = '{key: r_item.source_addr, tokens: r_tok, last_time: r_last};
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_item = i_in_data;
                    n_idx  = '0;
                    n_res  = '{drop: 1'b0, reason: REASON_BYPASS};
                end
            end
            ST_CMP: begin
                n_tok   = ram_rdata.tokens;
                n_last  = ram_rdata.last_time;
                n_delta = r_item.arrival_time_ns - ram_rdata.last_time;
                n_prod  = '0;
                n_mpl   = {r_rate, {(MPL_W-RATE_W){1'b0}}};
                n_sat   = 1'b0;
                n_cnt   = '0;
                if (!key_hit) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_MISS: begin
                if (r_used >= ENTRIES) begin
                    n_res = '{drop: 1'b0, reason: REASON_FULL};
                end else begin
                    // fresh bucket, no refill since the stamp equals now
                    ram_we    = 1'b1;
                    ram_waddr = r_used[AW-1:0];
                    ram_wdata = '{key: r_item.source_addr,
                                  tokens: (r_burst == '0) ? r_burst : r_burst - 1'b1,
                                  last_time: r_item.arrival_time_ns};
                    n_used    = r_used + 1'b1;
                    n_res     = (r_burst == '0) ? '{drop: 1'b1, reason: REASON_EMPTY}
                                               : '{drop: 1'b0, reason: REASON_SPENT};
                end
            end
            ST_MUL: begin
                // elapsed time times rate
                if (r_cnt == MUL_LAST) begin
                    // a product at or above 2^50 refills past any burst
                    n_sat   = |mac_next[PROD_W-1:SAT_BIT];
                    n_delta = {{(TIME_W-SAT_BIT+DIV_IN_LSB){1'b0}},
                               mac_next[SAT_BIT-1:DIV_IN_LSB]};
                    n_prod  = '0;
                    n_mpl   = RECIP;
                    n_cnt   = '0;
                end else begin
                    n_prod  = mac_next;
                    n_mpl   = {r_mpl[MPL_W-2:0], 1'b0};
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            ST_RECIP: begin
                // product over 512 times the reciprocal of 5^9
                n_prod = mac_next;
                n_mpl  = {r_mpl[MPL_W-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
            end
            ST_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = '{key: r_item.source_addr,
                              tokens: (tok_new == '0) ? tok_new : tok_new - 1'b1,
                              last_time: (refill == '0) ? r_last : r_item.arrival_time_ns};
                n_res     = (tok_new == '0) ? '{drop: 1'b1, reason: REASON_EMPTY}
                                           : '{drop: 1'b0, reason: REASON_SPENT};
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_rate      <= DEF_RATE;
            r_burst     <= DEF_BURST;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATE:  r_rate  <= i_cfg_wdata;
                    CFG_BURST: r_burst <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_item  <= n_item;
        r_tok   <= n_tok;
        r_last  <= n_last;
        r_delta <= n_delta;
        r_prod  <= n_prod;
        r_mpl   <= n_mpl;
        r_sat   <= n_sat;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_out   <= n_out;
    end

`include "per_source_token_bucket_policer_assert.svh"

    `PSTB_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= ENTRIES, "fill count overflow")
    `PSTB_ASSERT_IMPL(a_probe_range, i_clk, i_rst_n, r_state == ST_CMP, r_idx < r_used, "probe past fill")
    `PSTB_ASSERT_NEXT(a_used_step, i_clk, i_rst_n, 1'b1, (r_used == $past(r_used)) || (r_used == $past(r_used) + 1'b1), "fill count jump")
    `PSTB_ASSERT_IMPL(a_out_src, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == ST_OUT, "verdict loaded outside output state")

endmodule
`default_nettype wire
